@@ design/c_comment_strip_space_squeeze_unit_macros.svh @@
// Assertion helpers for the comment strip unit.
`ifndef C_COMMENT_STRIP_SPACE_SQUEEZE_UNIT_MACROS_SVH
`define C_COMMENT_STRIP_SPACE_SQUEEZE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CCSS_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");

`define CCSS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`else

`define CCSS_ASSERT_NEVER(lbl, cond)
`define CCSS_ASSERT_IMPLIES(lbl, ante, cons)

`endif

`endif

@@ design/ccss_pkg.sv @@
package ccss_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Queue between front and back; depth must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [3:0] {
        MODE_NONE  = 4'b0001,
        MODE_LINE  = 4'b0010,
        MODE_BLOCK = 4'b0100,
        MODE_CLOSE = 4'b1000
    } mode_t;

    typedef struct packed {
        logic       emit;
        logic       in_string;
        mode_t      mode;
    } decision_t;

    // One output beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } res_t;

    // One queue entry: up to two beats caused by one input byte.
    typedef struct packed {
        res_t       a;
        res_t       b;
        logic       has_b;
    } entry_t;

    typedef struct packed {
        logic       full;
        logic       empty;
    } qstat_t;

    function automatic decision_t decide(
        input logic [7:0] ch,
        input logic       has_next,
        input logic [7:0] nxt,
        input logic       in_str,
        input mode_t      mode
    );
        decision_t d;
        logic      next_slash;
        logic      next_star;
        logic      next_same;
        next_slash  = has_next && (nxt == CH_SLASH);
        next_star   = has_next && (nxt == CH_STAR);
        next_same   = has_next && (nxt == ch);
        d.emit      = 1'b0;
        d.in_string = in_str;
        d.mode      = mode;
        case (ch)
            CH_SLASH:
            begin
                if (in_str)
                begin
                    d.emit = 1'b1;
                end
                else if (mode == MODE_NONE)
                begin
                    if (next_slash)
                        d.mode = MODE_LINE;
                    else if (next_star)
                        d.mode = MODE_BLOCK;
                    else
                        d.emit = 1'b1;
                end
                else if (mode == MODE_CLOSE)
                begin
                    d.mode = MODE_NONE;
                end
            end
            CH_STAR:
            begin
                if (mode == MODE_BLOCK && next_slash)
                    d.mode = MODE_CLOSE;
                else if (mode == MODE_NONE)
                    d.emit = 1'b1;
            end
            CH_NL, CH_SPACE:
            begin
                if (!in_str && mode == MODE_NONE)
                    d.emit = !next_same;
                else if (in_str)
                    d.emit = 1'b1;
                else if (ch == CH_NL && mode == MODE_LINE)
                    d.mode = MODE_NONE;
            end
            CH_QUOTE:
            begin
                if (mode == MODE_NONE)
                begin
                    d.emit      = 1'b1;
                    d.in_string = !in_str;
                end
            end
            default:
            begin
                if (mode == MODE_NONE)
                    d.emit = 1'b1;
            end
        endcase
        return d;
    endfunction

endpackage

@@ design/ccss_front.sv @@
module ccss_front
    import ccss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  qstat_t     qstat,
    output logic       in_ready,
    output logic       push,
    output entry_t     push_entry
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       in_string_reg, in_string_next;
    mode_t      mode_reg, mode_next;

    decision_t  d0;
    decision_t  d1;
    logic       st1_string;
    mode_t      st1_mode;
    logic       r0;
    res_t       res0;
    res_t       res_fin;
    logic       accept;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        // held byte decided with the new byte as lookahead
        d0 = decide(held_byte_reg, 1'b1, in_char, in_string_reg, mode_reg);
        st1_string = held_valid_reg ? d0.in_string : in_string_reg;
        st1_mode   = held_valid_reg ? d0.mode      : mode_reg;
        r0         = held_valid_reg && d0.emit;
        // final byte decided with no lookahead
        d1 = decide(in_char, 1'b0, 8'h00, st1_string, st1_mode);

        res0.ch    = held_byte_reg;
        res0.valid = 1'b1;
        res0.last  = 1'b0;

        res_fin.ch    = d1.emit ? in_char : 8'h00;
        res_fin.valid = d1.emit;
        res_fin.last  = 1'b1;

        push = accept && (r0 || in_last);
        if (r0)
        begin
            push_entry.a     = res0;
            push_entry.b     = res_fin;
            push_entry.has_b = in_last;
        end
        else
        begin
            push_entry.a     = res_fin;
            push_entry.b     = res_fin;
            push_entry.has_b = 1'b0;
        end

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        in_string_next  = in_string_reg;
        mode_next       = mode_reg;
        if (accept)
        begin
            if (in_last)
            begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                in_string_next  = 1'b0;
                mode_next       = MODE_NONE;
            end
            else
            begin
                held_byte_next  = in_char;
                held_valid_next = 1'b1;
                in_string_next  = st1_string;
                mode_next       = st1_mode;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            in_string_reg  <= 1'b0;
            mode_reg       <= MODE_NONE;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            in_string_reg  <= in_string_next;
            mode_reg       <= mode_next;
        end
    end

endmodule

@@ design/ccss_queue.sv @@
module ccss_queue
    import ccss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output qstat_t qstat
);

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        // pointers wrap on their own since the depth is a power of two
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/ccss_back.sv @@
module ccss_back
    import ccss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head,
    input  qstat_t     qstat,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output res_t       out_res
);

    logic out_valid_reg, out_valid_next;
    logic half_reg, half_next;
    res_t out_res_reg, out_res_next;
    logic can_load;
    logic load;

    assign can_load  = !out_valid_reg || out_ready;
    assign load      = can_load && !qstat.empty;
    // an entry with two beats leaves the queue after its second beat
    assign pop       = load && (!head.has_b || half_reg);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        half_next      = half_reg;
        if (can_load)
            out_valid_next = !qstat.empty;
        if (load)
        begin
            out_res_next = half_reg ? head.b : head.a;
            half_next    = !pop;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

endmodule

@@ design/c_comment_strip_space_squeeze_unit.sv @@
// C comment stripper with whitespace squeeze.
// Input stream (s_*): one source text byte per beat, s_tlast on the final byte.
// Output stream (m_*): kept bytes; m_tuser is 1 when m_tdata holds a byte and 0
// for the empty end marker; m_tlast flags the final beat of a stream.
// The front stage holds one byte back for lookahead, decides it when the next
// byte arrives and pushes the 1 or 2 resulting beats, if any, as one entry into a
// 4-entry queue. The back stage drains the queue into an output register.
// A beat reaches m_tvalid from its queue entry through the output register; the
// second beat of a final byte follows the first from the same entry.
// Throughput: one input byte per cycle while the queue is not full; a final
// byte that yields two beats holds its queue entry until both have passed
// through the single output register.
// Reset clears the held byte, string and comment state, the queue and the
// output valid flag. When the receiver stalls, the queue fills and s_tready
// drops once it holds four entries; the output beat holds until taken.
`include "c_comment_strip_space_squeeze_unit_macros.svh"

module c_comment_strip_space_squeeze_unit
    import ccss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tuser,   // [0] char_valid
    output logic       m_tlast    // stream_end
);

    qstat_t qstat;
    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t head;
    res_t   out_res;

    ccss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .qstat      (qstat),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    ccss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    ccss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.ch;
    assign m_tuser = out_res.valid;
    assign m_tlast = out_res.last;

    // an empty marker carries no byte and only ends a stream
    `CCSS_ASSERT_NEVER(a_empty_marker_zero, m_tvalid && !m_tuser && m_tdata != 8'h00)
    `CCSS_ASSERT_IMPLIES(a_empty_marker_last, m_tvalid && !m_tuser, m_tlast)
    // a full queue always has a beat waiting at the output
    `CCSS_ASSERT_IMPLIES(a_full_has_output, !s_tready, m_tvalid)
    `CCSS_ASSERT_NEVER(a_pop_when_empty, pop && qstat.empty)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import ccss_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } text_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] in_char
    logic       s_tlast = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_char
    logic       m_tuser;           // [0] char_valid
    logic       m_tlast;           // stream_end

    c_comment_strip_space_squeeze_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic [7:0] held_ch = 8'h00;
    logic       held_ok = 1'b0;
    logic       in_quotes = 1'b0;
    mode_t      cmt_mode = MODE_NONE;

    text_beat_t pending_beats[$];
    text_beat_t want_beat;
    logic [7:0] text_buf[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_left = 0;
    int mismatches = 0;
    int cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_SHOWN)
            $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch("beat with nothing pending", m_tdata, 0);
            end
            else
            begin
                want_beat = pending_beats.pop_front();
                if (m_tdata !== want_beat.ch)
                    report_mismatch("out_char", m_tdata, want_beat.ch);
                if (m_tuser !== want_beat.valid)
                    report_mismatch("char_valid", m_tuser, want_beat.valid);
                if (m_tlast !== want_beat.last)
                    report_mismatch("stream_end", m_tlast, want_beat.last);
            end
        end
    end

    // Decides one byte against its lookahead; updates string and comment state.
    function automatic logic judge_byte(input logic [7:0] ch, input logic has_next,
                                        input logic [7:0] nxt);
        logic keep;
        keep = 1'b0;
        if (ch == CH_SLASH)
        begin
            if (in_quotes)
                keep = 1'b1;
            else if (cmt_mode == MODE_NONE)
            begin
                if (has_next && nxt == CH_SLASH)
                    cmt_mode = MODE_LINE;
                else if (has_next && nxt == CH_STAR)
                    cmt_mode = MODE_BLOCK;
                else
                    keep = 1'b1;
            end
            else if (cmt_mode == MODE_CLOSE)
                cmt_mode = MODE_NONE;
        end
        else if (ch == CH_STAR)
        begin
            if (cmt_mode == MODE_BLOCK && has_next && nxt == CH_SLASH)
                cmt_mode = MODE_CLOSE;
            else if (cmt_mode == MODE_NONE)
                keep = 1'b1;
        end
        else if (ch == CH_NL || ch == CH_SPACE)
        begin
            if (!in_quotes && cmt_mode == MODE_NONE)
                keep = !(has_next && nxt == ch);
            else if (in_quotes)
                keep = 1'b1;
            else if (ch == CH_NL && cmt_mode == MODE_LINE)
                cmt_mode = MODE_NONE;
        end
        else if (ch == CH_QUOTE)
        begin
            if (cmt_mode == MODE_NONE)
            begin
                keep      = 1'b1;
                in_quotes = !in_quotes;
            end
        end
        else if (cmt_mode == MODE_NONE)
        begin
            keep = 1'b1;
        end
        return keep;
    endfunction

    function automatic void strip_accept(input logic [7:0] ch, input logic last);
        text_beat_t b;
        if (held_ok && judge_byte(held_ch, 1'b1, ch))
        begin
            b = '{ch: held_ch, valid: 1'b1, last: 1'b0};
            pending_beats.push_back(b);
        end
        if (last)
        begin
            if (judge_byte(ch, 1'b0, 8'h00))
                b = '{ch: ch, valid: 1'b1, last: 1'b1};
            else
                b = '{ch: 8'h00, valid: 1'b0, last: 1'b1};
            pending_beats.push_back(b);
            held_ch   = 8'h00;
            held_ok   = 1'b0;
            in_quotes = 1'b0;
            cmt_mode  = MODE_NONE;
        end
        else
        begin
            held_ch = ch;
            held_ok = 1'b1;
        end
    endfunction

    // Called just after a rising edge; returns at the edge that takes the beat.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        strip_accept(ch, last);
    endtask

    task automatic send_stream();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void add_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            text_buf.push_back(txt[i]);
    endfunction

    function automatic logic [7:0] fill_char();
        case ($urandom_range(0, 6))
            0: return CH_SPACE;
            1: return CH_STAR;
            2: return CH_SLASH;
            3: return CH_NL;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Mostly well-formed C-like tokens, with some raw bytes mixed in.
    function automatic void build_stream();
        int         n_tok;
        int         len;
        logic [7:0] c;
        n_tok = $urandom_range(1, 8);
        repeat (n_tok)
        begin
            len = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
                0, 1: repeat (len) text_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
                2: repeat (len) text_buf.push_back(CH_SPACE);
                3: repeat (len) text_buf.push_back(CH_NL);
                4:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_SLASH);
                    repeat (len)
                    begin
                        c = fill_char();
                        text_buf.push_back(c == CH_NL ? CH_QUOTE : c);
                    end
                    text_buf.push_back(CH_NL);
                end
                5:
                begin
                    text_buf.push_back(CH_SLASH);
                    text_buf.push_back(CH_STAR);
                    repeat (len) text_buf.push_back(fill_char());
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
                6:
                begin
                    text_buf.push_back(CH_QUOTE);
                    repeat (len) text_buf.push_back(fill_char());
                    text_buf.push_back(CH_QUOTE);
                end
                7: text_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
                8: repeat (len) text_buf.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    case ($urandom_range(0, 4))
                        0: text_buf.push_back(CH_SLASH);
                        1: text_buf.push_back(CH_STAR);
                        2: text_buf.push_back(CH_NL);
                        3: text_buf.push_back(CH_SPACE);
                        default: text_buf.push_back(CH_QUOTE);
                    endcase
                end
            endcase
        end
    endfunction

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // single-byte stream
        text_buf.push_back(8'h00);
        send_stream();
        // line comment eats its newline, space run, trailing lone slash
        add_text("//c\nx  /");
        send_stream();
        // slash-star-slash comment, comment opener inside a string, newline run
        add_text("/*/\"/*\"\n\n*");
        send_stream();
        // backslash does not escape the quote; top byte value inside a string
        add_text("\\\"/*");
        text_buf.push_back(8'hFF);
        send_stream();
        // unterminated block comment: empty end marker
        add_text("/*");
        send_stream();
        wait_drain();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
        int sent;
        sent           = 0;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (sent < n_items)
        begin
            build_stream();
            sent += text_buf.size();
            send_stream();
        end
        wait_drain();
    endtask

    // receiver holds off long enough for the unit to fill and stall its input
    task automatic test_backpressure();
        int sent;
        sent           = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 300;
        while (sent < 60)
        begin
            build_stream();
            sent += text_buf.size();
            send_stream();
        end
        wait_drain();
    endtask

    task automatic test_pause_per_stream();
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        repeat (6)
        begin
            build_stream();
            send_stream();
            wait_drain();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(120, 0, 0);
        test_random(100, 87, 0);
        test_random(100, 0, 87);
        test_random(100, 7, 7);
        test_backpressure();
        test_pause_per_stream();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ccss_pkg.sv
design/ccss_front.sv
design/ccss_queue.sv
design/ccss_back.sv
design/c_comment_strip_space_squeeze_unit.sv
tb/sv/testbench.sv
